// ----- src/qet_pkg.sv -----
// Package: shared types, constants and the phase transition table for the encoder tracker.
`timescale 1ns / 1ps

package qet_pkg;

  localparam int ChannelsDefault = 8;
  localparam int QueueDepth      = 4;

  localparam int ChanW   = 3;
  localparam int PosW    = 16;
  localparam int SettleW = 8;
  localparam int DeltaW  = 8;
  localparam int ThreshW = 7;
  localparam int HoldW   = 16;
  localparam int CodeW   = 2;

  localparam int InDataW  = 8;
  localparam int OutDataW = 40;
  localparam int AddrW    = 5;
  localparam int RegW     = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_STEPS_PER_TURN = 3'd0;
  localparam logic [2:0] REG_SETTLE_SAMPLES = 3'd1;
  localparam logic [2:0] REG_LOGICAL_STEP   = 3'd2;
  localparam logic [2:0] REG_DIR_THRESHOLD  = 3'd3;
  localparam logic [2:0] REG_DIR_HOLD       = 3'd4;
  localparam logic [2:0] REG_SWAP_CHANNELS  = 3'd5;

  // step and direction codes
  localparam logic [CodeW-1:0] STEP_NONE = 2'd0;
  localparam logic [CodeW-1:0] STEP_CW   = 2'd1;
  localparam logic [CodeW-1:0] STEP_CCW  = 2'd2;

  typedef struct packed {
    logic [PosW-1:0]    steps_per_turn;
    logic [SettleW-1:0] settle_samples;
    logic [PosW-1:0]    logical_step;
    logic [ThreshW-1:0] dir_threshold;
    logic [HoldW-1:0]   dir_hold;
    logic               swap_channels;
  } cfg_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic             in_range;
    logic [1:0]       pins;
  } item_t;

  // entry: [5:4] step code, [1:0] next phase
  function automatic logic [7:0] phase_lookup(input logic [3:0] idx);
    logic [7:0] e;
    case (idx)
      4'd0:    e = 8'h00;
      4'd1:    e = 8'h11;
      4'd2:    e = 8'h22;
      4'd3:    e = 8'h03;
      4'd4:    e = 8'h20;
      4'd5:    e = 8'h01;
      4'd6:    e = 8'h02;
      4'd7:    e = 8'h13;
      4'd8:    e = 8'h10;
      4'd9:    e = 8'h01;
      4'd10:   e = 8'h02;
      4'd11:   e = 8'h23;
      4'd12:   e = 8'h00;
      4'd13:   e = 8'h21;
      4'd14:   e = 8'h12;
      4'd15:   e = 8'h03;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

// ----- src/quadrature_encoder_tracker_core.sv -----
// Top level of the multi-channel quadrature encoder tracker.
//
//   port group   dir  beat contents
//   s_axis_*     in   one pin sample: channel, pin_a, pin_b
//   m_axis_*     out  one result per sample: channel, positions, direction, step
//   APB          in   configuration registers at byte address 4*index
//
// One sample per cycle sustained while the output is not stalled; a taken beat passes through
// the front queue entry, then the channel update into the output register.
// Per-channel state is in flip-flops and clears at reset.
// The four-entry queue lets input beats be taken while the output is stalled;
// s_axis_tready drops only when the queue is full.
`timescale 1ns / 1ps

module quadrature_encoder_tracker_core
  import qet_pkg::*;
#(
  parameter int CHANNELS = ChannelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // [2:0] channel, [3] pin_a, [4] pin_b
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] out_channel, [18:3] physical_position, [34:19] logical_position,
  // [36:35] direction, [38:37] step_taken
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [RegW-1:0]     pwdata,
  output logic [RegW-1:0]     prdata,
  output logic                pready
);

  cfg_t  cfg;
  item_t push_item, pop_item;
  logic  q_push, q_full, q_pop, q_valid;

  qet_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qet_front #(.CHANNELS(CHANNELS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .swap_i        (cfg.swap_channels),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  qet_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  qet_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- src/qet_cfg.sv -----
// APB register block holding the tracker configuration.
`timescale 1ns / 1ps

module qet_cfg
  import qet_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [RegW-1:0]  pwdata,
  output logic [RegW-1:0]  prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_STEPS_PER_TURN: cfg_d.steps_per_turn = pwdata[PosW-1:0];
        REG_SETTLE_SAMPLES: cfg_d.settle_samples = pwdata[SettleW-1:0];
        REG_LOGICAL_STEP:   cfg_d.logical_step   = pwdata[PosW-1:0];
        REG_DIR_THRESHOLD:  cfg_d.dir_threshold  = pwdata[ThreshW-1:0];
        REG_DIR_HOLD:       cfg_d.dir_hold       = pwdata[HoldW-1:0];
        REG_SWAP_CHANNELS:  cfg_d.swap_channels  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEPS_PER_TURN: prdata = RegW'(cfg_q.steps_per_turn);
      REG_SETTLE_SAMPLES: prdata = RegW'(cfg_q.settle_samples);
      REG_LOGICAL_STEP:   prdata = RegW'(cfg_q.logical_step);
      REG_DIR_THRESHOLD:  prdata = RegW'(cfg_q.dir_threshold);
      REG_DIR_HOLD:       prdata = RegW'(cfg_q.dir_hold);
      REG_SWAP_CHANNELS:  prdata = RegW'(cfg_q.swap_channels);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_turn <= 16'd600;
      cfg_q.settle_samples <= 8'd4;
      cfg_q.logical_step   <= 16'd1;
      cfg_q.dir_threshold  <= 7'd2;
      cfg_q.dir_hold       <= 16'd100;
      cfg_q.swap_channels  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- src/qet_front.sv -----
// Front end: accepts input beats, checks the channel and maps the pins into a phase code.
`timescale 1ns / 1ps

module qet_front
  import qet_pkg::*;
#(
  parameter int CHANNELS = ChannelsDefault
) (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,
  input  logic               swap_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output item_t              q_item_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CmpW   = ChIdxW + ChanW;

  logic [ChanW-1:0] chan;
  logic             pin_a, pin_b;

  assign chan  = s_axis_tdata[ChanW-1:0];
  assign pin_a = s_axis_tdata[ChanW];
  assign pin_b = s_axis_tdata[ChanW+1];

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o.channel  = chan;
    q_item_o.in_range = CmpW'(chan) < CmpW'(CHANNELS);
    q_item_o.pins     = swap_i ? {pin_a, pin_b} : {pin_b, pin_a};
  end

endmodule

// ----- src/qet_queue.sv -----
// Short FIFO between the front end and the channel update stage.
`timescale 1ns / 1ps

module qet_queue
  import qet_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign full_o  = count_q == CntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- src/qet_back.sv -----
// Back end: per-channel phase, settle, position and direction update with output register.
`timescale 1ns / 1ps

module qet_back
  import qet_pkg::*;
#(
  parameter int CHANNELS = ChannelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_valid_i,
  input  item_t               q_item_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [1:0]         phase_q   [CHANNELS];
  logic [CodeW-1:0]   pend_q    [CHANNELS];
  logic [SettleW-1:0] settle_q  [CHANNELS];
  logic [PosW-1:0]    phys_q    [CHANNELS];
  logic [PosW-1:0]    logic_q   [CHANNELS];
  logic [DeltaW-1:0]  delta_q   [CHANNELS];
  logic [CodeW-1:0]   dir_q     [CHANNELS];
  logic [HoldW-1:0]   hold_q    [CHANNELS];

  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [ChIdxW-1:0]  ci;
  logic               upd;
  logic [7:0]         entry;
  logic [CodeW-1:0]   emit, step;
  logic [1:0]         phase_d;
  logic [CodeW-1:0]   pend_d, dir_d;
  logic [SettleW-1:0] settle_d;
  logic [PosW-1:0]    phys_d, logic_d, phys_inc, phys_dec;
  logic [DeltaW-1:0]  delta_d, delta_inc, delta_dec, th_pos, th_neg;
  logic [HoldW-1:0]   hold_d;

  assign ci      = ChIdxW'(q_item_i.channel);
  assign q_pop_o = q_valid_i && (!out_valid_q || m_axis_tready);
  assign upd     = q_pop_o && q_item_i.in_range;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign phys_inc  = phys_q[ci] + PosW'(1);
  assign phys_dec  = phys_q[ci] - PosW'(1);
  assign delta_inc = delta_q[ci] + DeltaW'(1);
  assign delta_dec = delta_q[ci] - DeltaW'(1);
  assign th_pos    = DeltaW'(cfg_i.dir_threshold);
  assign th_neg    = DeltaW'(~th_pos + DeltaW'(1));

  always_comb begin
    settle_d = (settle_q[ci] != '0) ? settle_q[ci] - SettleW'(1) : '0;
    if (hold_q[ci] != '0) begin
      hold_d = hold_q[ci] - HoldW'(1);
      dir_d  = dir_q[ci];
    end else begin
      hold_d = '0;
      dir_d  = STEP_NONE;
    end

    entry   = phase_lookup({phase_q[ci], q_item_i.pins});
    phase_d = entry[1:0];
    emit    = entry[5:4];
    pend_d  = pend_q[ci];
    step    = STEP_NONE;

    if (emit != STEP_NONE) begin
      if (pend_q[ci] == STEP_NONE) begin
        pend_d   = emit;
        settle_d = cfg_i.settle_samples;
      end else if (emit == pend_q[ci]) begin
        settle_d = cfg_i.settle_samples;
      end else begin
        pend_d   = STEP_NONE;
        settle_d = '0;
      end
    end else if (pend_q[ci] != STEP_NONE && settle_d == '0) begin
      step   = pend_q[ci];
      pend_d = STEP_NONE;
    end

    phys_d  = phys_q[ci];
    logic_d = logic_q[ci];
    delta_d = delta_q[ci];
    if (step == STEP_CCW) begin
      phys_d  = (phys_dec >= cfg_i.steps_per_turn) ? cfg_i.steps_per_turn - PosW'(1) : phys_dec;
      logic_d = logic_q[ci] - cfg_i.logical_step;
      delta_d = delta_dec;
      if ($signed(delta_dec) <= $signed(th_neg)) begin
        delta_d = '0;
        dir_d   = STEP_CCW;
        hold_d  = cfg_i.dir_hold;
      end
    end else if (step != STEP_NONE) begin
      phys_d  = (phys_inc >= cfg_i.steps_per_turn) ? '0 : phys_inc;
      logic_d = logic_q[ci] + cfg_i.logical_step;
      delta_d = delta_inc;
      if ($signed(delta_inc) >= $signed(th_pos)) begin
        delta_d = '0;
        dir_d   = STEP_CW;
        hold_d  = cfg_i.dir_hold;
      end
    end

    if (q_item_i.in_range) begin
      out_data_d = {1'b0, step, dir_d, logic_d, phys_d, q_item_i.channel};
    end else begin
      out_data_d = {1'b0, STEP_NONE, STEP_NONE, PosW'(0), PosW'(0), q_item_i.channel};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i]  <= '0;
        pend_q[i]   <= STEP_NONE;
        settle_q[i] <= '0;
        phys_q[i]   <= '0;
        logic_q[i]  <= '0;
        delta_q[i]  <= '0;
        dir_q[i]    <= STEP_NONE;
        hold_q[i]   <= '0;
      end
    end else if (upd) begin
      phase_q[ci]  <= phase_d;
      pend_q[ci]   <= pend_d;
      settle_q[ci] <= settle_d;
      phys_q[ci]   <= phys_d;
      logic_q[ci]  <= logic_d;
      delta_q[ci]  <= delta_d;
      dir_q[ci]    <= dir_d;
      hold_q[ci]   <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ----- sim/quadrature_encoder_tracker_core_tb.sv -----
// Testbench: drives random and directed pin samples into the encoder tracker and checks every result beat.
`timescale 1ns / 1ps

module quadrature_encoder_tracker_core_tb;
  import qet_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int NCHAN      = 8;

  localparam logic [1:0] RDY_OPEN   = 2'd0;
  localparam logic [1:0] RDY_COIN   = 2'd1;
  localparam logic [1:0] RDY_CHOKED = 2'd2;
  localparam logic [1:0] RDY_EVERY3 = 2'd3;

  // next gray phase, indexed by current phase
  localparam logic [7:0] CW_NEXT  = 8'b10_00_11_01;
  localparam logic [7:0] CCW_NEXT = 8'b01_11_00_10;

  class tracker_ledger;
    // transition entries, index {prev_phase, pins}: [5:4] step, [1:0] next phase
    localparam logic [127:0] PHASE_STEP = {
      8'h03, 8'h12, 8'h21, 8'h00, 8'h23, 8'h02, 8'h01, 8'h10,
      8'h13, 8'h02, 8'h01, 8'h20, 8'h03, 8'h22, 8'h11, 8'h00};

    typedef struct packed {
      logic [2:0]  ch;
      logic [15:0] phys;
      logic [15:0] lpos;
      logic [1:0]  dir;
      logic [1:0]  step;
    } position_t;

    position_t due_positions[$];
    int        errors;

    logic [15:0] turn_len;
    logic [7:0]  settle_len;
    logic [15:0] unit;
    logic [6:0]  thresh;
    logic [15:0] hold_len;
    logic        swap;

    logic [1:0]        phase_st   [NCHAN];
    logic [1:0]        pending    [NCHAN];
    logic [7:0]        settle_cnt [NCHAN];
    logic [15:0]       phys       [NCHAN];
    logic [15:0]       lpos       [NCHAN];
    logic signed [7:0] delta      [NCHAN];
    logic [1:0]        dir_now    [NCHAN];
    logic [15:0]       hold_cnt   [NCHAN];

    function new();
      errors     = 0;
      turn_len   = 16'd600;
      settle_len = 8'd4;
      unit       = 16'd1;
      thresh     = 7'd2;
      hold_len   = 16'd100;
      swap       = 1'b0;
      for (int c = 0; c < NCHAN; c++) begin
        phase_st[c]   = '0;
        pending[c]    = STEP_NONE;
        settle_cnt[c] = '0;
        phys[c]       = '0;
        lpos[c]       = '0;
        delta[c]      = '0;
        dir_now[c]    = STEP_NONE;
        hold_cnt[c]   = '0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_STEPS_PER_TURN: turn_len   = val[15:0];
        REG_SETTLE_SAMPLES: settle_len = val[7:0];
        REG_LOGICAL_STEP:   unit       = val[15:0];
        REG_DIR_THRESHOLD:  thresh     = val[6:0];
        REG_DIR_HOLD:       hold_len   = val[15:0];
        REG_SWAP_CHANNELS:  swap       = val[0];
        default: ;
      endcase
    endfunction

    function int pending_count();
      return due_positions.size();
    endfunction

    function void move_position(logic [2:0] ch, logic [1:0] step);
      logic [15:0]       p;
      logic signed [7:0] d;
      p = phys[ch];
      d = delta[ch];
      if (step == STEP_CCW) begin
        p = p - 16'd1;
        if (p >= turn_len) p = turn_len - 16'd1;
        lpos[ch] = lpos[ch] - unit;
        d = d - 8'sd1;
        if (int'(d) <= -int'(thresh)) begin
          d = '0;
          dir_now[ch] = STEP_CCW;
          hold_cnt[ch] = hold_len;
        end
      end else begin
        p = p + 16'd1;
        if (p >= turn_len) p = '0;
        lpos[ch] = lpos[ch] + unit;
        d = d + 8'sd1;
        if (int'(d) >= int'(thresh)) begin
          d = '0;
          dir_now[ch] = STEP_CW;
          hold_cnt[ch] = hold_len;
        end
      end
      phys[ch]  = p;
      delta[ch] = d;
    endfunction

    function void note_sample(logic [2:0] ch, logic pa, logic pb);
      logic [1:0] pins;
      logic [7:0] entry;
      logic [1:0] emit;
      logic [1:0] step;
      position_t  want;
      step = STEP_NONE;
      if (settle_cnt[ch] != 0) settle_cnt[ch]--;
      if (hold_cnt[ch] != 0) hold_cnt[ch]--;
      else dir_now[ch] = STEP_NONE;
      pins  = swap ? {pa, pb} : {pb, pa};
      entry = PHASE_STEP[{phase_st[ch], pins}*8 +: 8];
      phase_st[ch] = entry[1:0];
      emit = entry[5:4];
      if (emit != STEP_NONE) begin
        if (pending[ch] == STEP_NONE) begin
          pending[ch]    = emit;
          settle_cnt[ch] = settle_len;
        end else if (emit == pending[ch]) begin
          settle_cnt[ch] = settle_len;
        end else begin
          pending[ch]    = STEP_NONE;
          settle_cnt[ch] = '0;
        end
      end else if (pending[ch] != STEP_NONE && settle_cnt[ch] == 0) begin
        step = pending[ch];
        pending[ch] = STEP_NONE;
      end
      if (step != STEP_NONE) move_position(ch, step);
      want.ch   = ch;
      want.phys = phys[ch];
      want.lpos = lpos[ch];
      want.dir  = dir_now[ch];
      want.step = step;
      due_positions.push_back(want);
    endfunction

    task report(string what, int got, int want);
      if (errors < 100) $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] data);
      position_t want;
      if (due_positions.size() == 0) begin
        report("beat with nothing outstanding, channel", data[2:0], 0);
        return;
      end
      want = due_positions.pop_front();
      if (data[2:0] != want.ch) report("out_channel", data[2:0], want.ch);
      if (data[18:3] != want.phys) report("physical_position", data[18:3], want.phys);
      if (data[34:19] != want.lpos) report("logical_position", data[34:19], want.lpos);
      if (data[36:35] != want.dir) report("direction", data[36:35], want.dir);
      if (data[38:37] != want.step) report("step_taken", data[38:37], want.step);
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // [2:0] channel, [3] pin_a, [4] pin_b
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [2:0] out_channel, [18:3] physical_position, [34:19] logical_position,
  // [36:35] direction, [38:37] step_taken
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [RegW-1:0]     pwdata        = '0;
  logic [RegW-1:0]     prdata;
  logic                pready;

  tracker_ledger book;
  logic [1:0]    gen_pins [NCHAN];
  logic          swap_now;
  logic [1:0]    ready_mode = RDY_OPEN;
  int            ready_left = 0;
  int            cyc        = 0;
  int            idle_cycles = 0;

  quadrature_encoder_tracker_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  // receiver stall pattern
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (ready_left == 0) begin
      ready_mode <= 2'($urandom_range(0, 3));
      ready_left <= $urandom_range(32, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RDY_OPEN:   m_axis_tready <= 1'b1;
      RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RDY_CHOKED: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:    m_axis_tready <= (cyc % 3 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL quadrature_encoder_tracker_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.set_reg(idx, val);
    if (idx == REG_SWAP_CHANNELS) swap_now = val[0];
    @(posedge clk_i);
  endtask

  task automatic set_all(input int spt, input int settle, input int lstep, input int th,
                         input int hold, input int swp);
    write_reg(REG_STEPS_PER_TURN, spt);
    write_reg(REG_SETTLE_SAMPLES, settle);
    write_reg(REG_LOGICAL_STEP, lstep);
    write_reg(REG_DIR_THRESHOLD, th);
    write_reg(REG_DIR_HOLD, hold);
    write_reg(REG_SWAP_CHANNELS, swp);
  endtask

  task automatic push_sample(input logic [2:0] ch, input logic [1:0] pins);
    logic pa;
    logic pb;
    pa = swap_now ? pins[1] : pins[0];
    pb = swap_now ? pins[0] : pins[1];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pb, pa, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_sample(ch, pa, pb);
    gen_pins[ch] = pins;
  endtask

  task automatic drain(input int settle_cycles);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (book.pending_count() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int count, input int chan_top, input bit mid_pause);
    int         burst;
    int         gap;
    int         pick;
    logic [2:0] ch;
    logic [1:0] pins;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) drain(4);
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = $urandom_range(0, 5);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst--;
      ch   = 3'($urandom_range(0, chan_top));
      pick = $urandom_range(0, 99);
      pins = gen_pins[ch];
      if (pick < 40) pins = gen_pins[ch];
      else if (pick < 68) pins = CW_NEXT[gen_pins[ch]*2 +: 2];
      else if (pick < 88) pins = CCW_NEXT[gen_pins[ch]*2 +: 2];
      else if (pick < 95) pins = gen_pins[ch] ^ 2'b11;  // illegal jump
      else pins = 2'($urandom_range(0, 3));
      push_sample(ch, pins);
    end
    drain(4);
  endtask

  initial begin
    logic [1:0] walk7 [16];
    logic [1:0] walk0 [11];
    book = new();
    swap_now = 1'b0;
    for (int c = 0; c < NCHAN; c++) gen_pins[c] = 2'd0;
    // every {prev, pins} pair once on the top channel
    walk7 = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
              2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
    // release after settle, matching step restarts, opposing step cancels
    walk0 = '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 16; i++) push_sample(3'd7, walk7[i]);
    for (int i = 0; i < 11; i++) push_sample(3'd0, walk0[i]);
    drain(4);

    set_all(600, 0, 1, 1, 0, 0);
    run_phase(200, 7, 1'b1);
    set_all(0, 1, 65535, 127, 65535, 1);
    run_phase(180, 7, 1'b0);
    set_all(1, 255, 0, 5, 3, 0);
    run_phase(100, 3, 1'b0);
    set_all(65535, 2, 32768, 0, 10, 1);
    run_phase(200, 7, 1'b0);
    // positions now sit beyond the shortened turn
    set_all(5, 0, 7, 3, 1, 0);
    run_phase(200, 7, 1'b0);
    repeat (3) begin
      set_all($urandom_range(1, 40), $urandom_range(0, 6), $urandom_range(0, 65535),
              $urandom_range(0, 8), $urandom_range(0, 300), $urandom_range(0, 1));
      run_phase(150, $urandom_range(1, 7), 1'b0);
    end

    drain(8);
    if (book.errors == 0 && book.pending_count() == 0) begin
      $display("PASS quadrature_encoder_tracker_core");
    end else begin
      $display("FAIL quadrature_encoder_tracker_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/qet_pkg.sv
src/qet_cfg.sv
src/qet_front.sv
src/qet_queue.sv
src/qet_back.sv
src/quadrature_encoder_tracker_core.sv
sim/quadrature_encoder_tracker_core_tb.sv
